// ===== rtl/sks_pkg.sv =====
// Shared types, constants and command codes for the seek steering step.
package sks_pkg;

    localparam int FRAC_BITS  = 8;
    localparam int FIELD_W    = 24;
    localparam int DT_W       = 16;
    localparam int AT_FRAC    = 8;
    localparam int BOUND_W    = 12;
    localparam int SIZE_W     = 10;
    localparam int LIMIT_W    = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int VEC_W  = 36;
    localparam int MAG_W  = 35;
    localparam int LIM_W  = LIMIT_W + FRAC_BITS;
    localparam int MUL_W  = 32;
    localparam int PROD_W = 61;
    localparam int WIDE_BIT = 30;
    localparam int SQ_IN_W = 62;
    localparam int ROOT_W  = 31;
    localparam int DIVD_W  = 54;
    localparam int DIVS_W  = 31;

    localparam logic [BOUND_W-1:0] BOUND_X_RST  = BOUND_W'(1280);
    localparam logic [BOUND_W-1:0] BOUND_Y_RST  = BOUND_W'(800);
    localparam logic [LIMIT_W-1:0] ARRIVE_RST   = LIMIT_W'(512);
    localparam logic [LIMIT_W-1:0] ACCEL_RST    = LIMIT_W'(20);
    localparam logic [LIMIT_W-1:0] SPEED_RST    = LIMIT_W'(150);
    localparam logic [SIZE_W-1:0]  SPRITE_RST   = SIZE_W'(64);
    localparam logic signed [FIELD_W-1:0] POS_X_RST = FIELD_W'(1220 << FRAC_BITS);
    localparam logic signed [FIELD_W-1:0] POS_Y_RST = FIELD_W'(700 << FRAC_BITS);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BOUND_X,
        REG_BOUND_Y,
        REG_ARRIVE_TIME,
        REG_ACCEL_LIMIT,
        REG_SPEED_LIMIT,
        REG_SPRITE_WIDTH,
        REG_SPRITE_HEIGHT
    } sks_reg_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_ADIV_A,
        OP_ADIV_B,
        OP_SET_A,
        OP_SET_B,
        OP_LIM_ACC,
        OP_LIM_SPD,
        OP_SQ_A,
        OP_SQ_B,
        OP_SQ_SUM,
        OP_LIM_SQ,
        OP_SHIFT,
        OP_SQRT,
        OP_ZERO,
        OP_SCALE_A,
        OP_SCALE_B,
        OP_SDIV_A,
        OP_SDIV_B,
        OP_MDT_A,
        OP_MDT_B,
        OP_VEL_A,
        OP_VEL_B,
        OP_COMMIT_VEL,
        OP_POS_A,
        OP_POS_B,
        OP_COMMIT_POS
    } sks_op_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_ADIV_A,
        S_ADIV_A_W,
        S_ADIV_B,
        S_ADIV_B_W,
        S_LIM_INIT,
        S_LIM_CHK,
        S_SQ_A,
        S_SQ_B,
        S_SQ_SUM,
        S_LIM_SQ,
        S_LIM_CMP,
        S_SHIFT,
        S_SQRT,
        S_SQRT_W,
        S_SC_A,
        S_SD_A,
        S_SD_A_W,
        S_SC_B,
        S_SD_B,
        S_SD_B_W,
        S_LIM_END,
        S_MV_A,
        S_AV_A,
        S_MV_B,
        S_AV_B,
        S_VCOMMIT,
        S_MP_A,
        S_AP_A,
        S_MP_B,
        S_AP_B,
        S_COMMIT
    } sks_state_t;

    typedef struct packed {
        sks_op_t op;
    } sks_cmd_t;

    typedef struct packed {
        logic over;       // a component alone exceeds the limit
        logic fits;       // squared sum within squared limit
        logic wide;       // a magnitude still too wide to square
        logic m_zero;     // root came out zero
        logic div_busy;
        logic sqrt_busy;
    } sks_status_t;

endpackage

// ===== rtl/sks_in_if.sv =====
// Input channel: goal point and frame time.
interface sks_in_if;
    import sks_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] goal_x;
    logic signed [FIELD_W-1:0] goal_y;
    logic [DT_W-1:0]           time_step;

    modport source (output valid, goal_x, goal_y, time_step, input ready);
    modport sink   (input valid, goal_x, goal_y, time_step, output ready);
endinterface

// ===== rtl/sks_out_if.sv =====
// Output channel: new position and velocity.
interface sks_out_if;
    import sks_pkg::*;

    logic                      valid;
    logic                      ready;
    logic signed [FIELD_W-1:0] position_x;
    logic signed [FIELD_W-1:0] position_y;
    logic signed [FIELD_W-1:0] velocity_x;
    logic signed [FIELD_W-1:0] velocity_y;

    modport source (output valid, position_x, position_y, velocity_x, velocity_y,
                    input ready);
    modport sink   (input valid, position_x, position_y, velocity_x, velocity_y,
                    output ready);
endinterface

// ===== rtl/sks_cfg_if.sv =====
// Configuration write channel.
interface sks_cfg_if;
    import sks_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/seek_steering_kinematic_step.sv =====
// Top level of the seek steering step: controller plus datapath.
//
//  channel   dir   beat payload                                   handshake
//  target    in    goal_x, goal_y (Q15.8), time_step (Q0.16)      valid/ready
//  update    out   position_x/y, velocity_x/y (Q15.8)             valid/ready
//  cfg       in    index (register number), data                  valid/ready
//
// One item at a time. Each magnitude clamp that engages adds a square
// root plus two divisions, run on the bit-serial square root and the
// radix-2 divider.
// Reset restores the register defaults and the starting position at once.
// The result sits in an output register; a stalled update beat holds the
// next result at its commit step while target stays blocked.
module seek_steering_kinematic_step (
    input  logic      clk,
    input  logic      rst_n,
    sks_in_if.sink    target,
    sks_out_if.source update,
    sks_cfg_if.sink   cfg
);
    import sks_pkg::*;

    sks_cmd_t    cmd;
    sks_status_t status;

    // register writes never stall
    assign cfg.ready = 1'b1;

    sks_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (target.valid),
        .in_ready  (target.ready),
        .out_valid (update.valid),
        .out_ready (update.ready),
        .status    (status),
        .cmd       (cmd)
    );

    sks_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .cfg_we     (cfg.valid),
        .cfg_index  (cfg.index),
        .cfg_data   (cfg.data),
        .goal_x     (target.goal_x),
        .goal_y     (target.goal_y),
        .time_step  (target.time_step),
        .position_x (update.position_x),
        .position_y (update.position_y),
        .velocity_x (update.velocity_x),
        .velocity_y (update.velocity_y)
    );
endmodule

// ===== rtl/sks_div.sv =====
// Restoring radix-2 unsigned divider, one quotient bit per cycle.
module sks_div (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [sks_pkg::DIVD_W-1:0] dividend,
    input  logic [sks_pkg::DIVS_W-1:0] divisor,
    output logic                       busy,
    output logic [sks_pkg::DIVD_W-1:0] quotient
);
    import sks_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [DIVD_W-1:0] quo_reg, quo_next;
    logic [DIVS_W-1:0] rem_reg, rem_next;
    logic [DIVS_W-1:0] dvs_reg, dvs_next;
    logic [DIVS_W:0]   rem_sh;
    logic [DIVS_W:0]   diff;

    always_comb
    begin
        rem_sh    = {rem_reg, quo_reg[DIVD_W-1]};
        diff      = rem_sh - {1'b0, dvs_reg};
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(DIVD_W);
            quo_next  = dividend;
            rem_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (rem_sh >= {1'b0, dvs_reg})
            begin
                rem_next = diff[DIVS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[DIVS_W-1:0];
                quo_next = {quo_reg[DIVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;
endmodule

// ===== rtl/sks_sqrt.sv =====
// Digit-by-digit floor square root, one root bit per cycle.
module sks_sqrt (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [sks_pkg::SQ_IN_W-1:0] radicand,
    output logic                        busy,
    output logic [sks_pkg::ROOT_W-1:0]  root
);
    import sks_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W + 1);
    localparam int REM_W = ROOT_W + 2;

    logic               busy_reg, busy_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [SQ_IN_W-1:0] n_reg, n_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [REM_W+1:0]   rem_t;
    logic [REM_W+1:0]   trial;

    always_comb
    begin
        rem_t     = {rem_reg, n_reg[SQ_IN_W-1 -: 2]};
        trial     = (REM_W + 2)'({root_reg, 2'b01});
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        n_next    = n_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(ROOT_W);
            n_next    = radicand;
            rem_next  = '0;
            root_next = '0;
        end
        else if (busy_reg)
        begin
            if (rem_t >= trial)
            begin
                rem_next  = REM_W'(rem_t - trial);
                root_next = {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = rem_t[REM_W-1:0];
                root_next = {root_reg[ROOT_W-2:0], 1'b0};
            end
            n_next   = {n_reg[SQ_IN_W-3:0], 2'b00};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign busy = busy_reg;
    assign root = root_reg;
endmodule

// ===== rtl/sks_dp.sv =====
// Datapath: config registers, agent state, working vector, shared multiplier.
module sks_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  sks_pkg::sks_cmd_t                  cmd,
    output sks_pkg::sks_status_t               status,
    input  logic                               cfg_we,
    input  logic [sks_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [sks_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic signed [sks_pkg::FIELD_W-1:0] goal_x,
    input  logic signed [sks_pkg::FIELD_W-1:0] goal_y,
    input  logic [sks_pkg::DT_W-1:0]           time_step,
    output logic signed [sks_pkg::FIELD_W-1:0] position_x,
    output logic signed [sks_pkg::FIELD_W-1:0] position_y,
    output logic signed [sks_pkg::FIELD_W-1:0] velocity_x,
    output logic signed [sks_pkg::FIELD_W-1:0] velocity_y
);
    import sks_pkg::*;

    localparam logic signed [VEC_W-1:0] SAT_HI = VEC_W'((64'sd1 <<< (FIELD_W - 1)) - 1);
    localparam logic signed [VEC_W-1:0] SAT_LO = -VEC_W'(64'sd1 <<< (FIELD_W - 1));

    function automatic logic [MAG_W-1:0] mag(input logic signed [VEC_W-1:0] v);
        logic [VEC_W-1:0] n;
        n = v[VEC_W-1] ? VEC_W'(-v) : VEC_W'(v);
        return n[MAG_W-1:0];
    endfunction

    function automatic logic signed [FIELD_W-1:0] sat24(input logic signed [VEC_W-1:0] v);
        logic signed [VEC_W-1:0] r;
        if (v > SAT_HI)
            r = SAT_HI;
        else if (v < SAT_LO)
            r = SAT_LO;
        else
            r = v;
        return r[FIELD_W-1:0];
    endfunction

    function automatic logic signed [FIELD_W-1:0] wrap_axis(
        input logic signed [VEC_W-1:0] p,
        input logic [BOUND_W-1:0]      bound,
        input logic [SIZE_W-1:0]       size
    );
        logic signed [VEC_W-1:0] hi;
        logic signed [VEC_W-1:0] lo;
        logic signed [VEC_W-1:0] r;
        hi = VEC_W'(bound) << FRAC_BITS;
        lo = -(VEC_W'(size) << FRAC_BITS);
        if (p > hi)
            r = lo;
        else if (p < lo)
            r = hi;
        else
            r = p;
        return sat24(r);
    endfunction

    // configuration
    logic [BOUND_W-1:0] bound_x_reg, bound_y_reg;
    logic [LIMIT_W-1:0] arrive_reg, accel_reg, speed_reg;
    logic [SIZE_W-1:0]  width_reg, height_reg;

    // agent state
    logic signed [FIELD_W-1:0] pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;

    // result beat
    logic signed [FIELD_W-1:0] opx_reg, opy_reg, ovx_reg, ovy_reg;

    // working set
    logic signed [VEC_W-1:0] va_reg, vb_reg;
    logic [MAG_W-1:0]        ma_reg, mb_reg;
    logic [LIM_W-1:0]        lim_reg;
    logic [PROD_W-1:0]       prod_reg, sum_reg;
    logic [DT_W-1:0]         dt_reg;
    logic                    sgn_reg;

    logic [MUL_W-1:0]        mul_a, mul_b;
    logic [2*MUL_W-1:0]      mul_full;
    logic                    mul_en;
    logic [VEC_W-1:0]        step;
    logic [VEC_W-1:0]        step_s;
    logic signed [VEC_W-1:0] half_w, half_h;
    logic [LIMIT_W-1:0]      at_eff;

    logic                    div_start, div_busy;
    logic [DIVD_W-1:0]       div_dividend, div_quo;
    logic [DIVS_W-1:0]       div_divisor;
    logic [VEC_W-1:0]        quo_v;
    logic                    sqrt_start, sqrt_busy;
    logic [ROOT_W-1:0]       root;

    sks_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    sks_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (SQ_IN_W'(sum_reg)),
        .busy     (sqrt_busy),
        .root     (root)
    );

    always_comb
    begin
        at_eff = (arrive_reg == '0) ? LIMIT_W'(1) : arrive_reg;
        half_w = VEC_W'(width_reg) << (FRAC_BITS - 1);
        half_h = VEC_W'(height_reg) << (FRAC_BITS - 1);
        step   = VEC_W'(prod_reg >> DT_W);
        step_s = sgn_reg ? -step : step;
        quo_v  = div_quo[VEC_W-1:0];

        mul_a  = '0;
        mul_b  = '0;
        mul_en = 1'b1;
        unique case (cmd.op)
            OP_SQ_A:    begin mul_a = ma_reg[MUL_W-1:0]; mul_b = ma_reg[MUL_W-1:0]; end
            OP_SQ_B:    begin mul_a = mb_reg[MUL_W-1:0]; mul_b = mb_reg[MUL_W-1:0]; end
            OP_LIM_SQ:  begin mul_a = MUL_W'(lim_reg);   mul_b = MUL_W'(lim_reg);   end
            OP_SCALE_A: begin mul_a = ma_reg[MUL_W-1:0]; mul_b = MUL_W'(lim_reg);   end
            OP_SCALE_B: begin mul_a = mb_reg[MUL_W-1:0]; mul_b = MUL_W'(lim_reg);   end
            OP_MDT_A:   begin mul_a = MUL_W'(mag(va_reg)); mul_b = MUL_W'(dt_reg);  end
            OP_MDT_B:   begin mul_a = MUL_W'(mag(vb_reg)); mul_b = MUL_W'(dt_reg);  end
            default:    mul_en = 1'b0;
        endcase
        mul_full = mul_a * mul_b;

        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = DIVS_W'(at_eff);
        unique case (cmd.op)
            OP_ADIV_A:
            begin
                div_start    = 1'b1;
                div_dividend = DIVD_W'(mag(va_reg)) << AT_FRAC;
            end
            OP_ADIV_B:
            begin
                div_start    = 1'b1;
                div_dividend = DIVD_W'(mag(vb_reg)) << AT_FRAC;
            end
            OP_SDIV_A, OP_SDIV_B:
            begin
                div_start    = 1'b1;
                div_dividend = prod_reg[DIVD_W-1:0];
                div_divisor  = root;
            end
            default: ;
        endcase

        sqrt_start = (cmd.op == OP_SQRT);

        status.over      = (ma_reg > MAG_W'(lim_reg)) || (mb_reg > MAG_W'(lim_reg));
        status.fits      = (sum_reg <= prod_reg);
        status.wide      = (ma_reg[MAG_W-1:WIDE_BIT] != '0) || (mb_reg[MAG_W-1:WIDE_BIT] != '0);
        status.m_zero    = (root == '0);
        status.div_busy  = div_busy;
        status.sqrt_busy = sqrt_busy;
    end

    // configuration and agent state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_x_reg <= BOUND_X_RST;
            bound_y_reg <= BOUND_Y_RST;
            arrive_reg  <= ARRIVE_RST;
            accel_reg   <= ACCEL_RST;
            speed_reg   <= SPEED_RST;
            width_reg   <= SPRITE_RST;
            height_reg  <= SPRITE_RST;
            pos_x_reg   <= POS_X_RST;
            pos_y_reg   <= POS_Y_RST;
            vel_x_reg   <= '0;
            vel_y_reg   <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (sks_reg_t'(cfg_index))
                    REG_BOUND_X:       bound_x_reg <= cfg_data[BOUND_W-1:0];
                    REG_BOUND_Y:       bound_y_reg <= cfg_data[BOUND_W-1:0];
                    REG_ARRIVE_TIME:   arrive_reg  <= cfg_data[LIMIT_W-1:0];
                    REG_ACCEL_LIMIT:   accel_reg   <= cfg_data[LIMIT_W-1:0];
                    REG_SPEED_LIMIT:   speed_reg   <= cfg_data[LIMIT_W-1:0];
                    REG_SPRITE_WIDTH:  width_reg   <= cfg_data[SIZE_W-1:0];
                    REG_SPRITE_HEIGHT: height_reg  <= cfg_data[SIZE_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.op == OP_COMMIT_VEL)
            begin
                vel_x_reg <= sat24(va_reg);
                vel_y_reg <= sat24(vb_reg);
            end
            if (cmd.op == OP_COMMIT_POS)
            begin
                pos_x_reg <= wrap_axis(va_reg, bound_x_reg, width_reg);
                pos_y_reg <= wrap_axis(vb_reg, bound_y_reg, height_reg);
            end
        end
    end

    // working registers and result beat
    always_ff @(posedge clk)
    begin
        if (mul_en)
        begin
            prod_reg <= mul_full[PROD_W-1:0];
        end
        unique case (cmd.op)
            OP_LOAD:
            begin
                dt_reg <= time_step;
                va_reg <= VEC_W'(goal_x) - (VEC_W'(pos_x_reg) + half_w);
                vb_reg <= VEC_W'(goal_y) - (VEC_W'(pos_y_reg) + half_h);
            end
            OP_SET_A:   va_reg <= va_reg[VEC_W-1] ? -quo_v : quo_v;
            OP_SET_B:   vb_reg <= vb_reg[VEC_W-1] ? -quo_v : quo_v;
            OP_LIM_ACC:
            begin
                ma_reg  <= mag(va_reg);
                mb_reg  <= mag(vb_reg);
                lim_reg <= LIM_W'(accel_reg) << FRAC_BITS;
            end
            OP_LIM_SPD:
            begin
                ma_reg  <= mag(va_reg);
                mb_reg  <= mag(vb_reg);
                lim_reg <= LIM_W'(speed_reg) << FRAC_BITS;
            end
            OP_SQ_B:    sum_reg <= prod_reg;
            OP_SQ_SUM:  sum_reg <= sum_reg + prod_reg;
            OP_SHIFT:
            begin
                ma_reg <= ma_reg >> 1;
                mb_reg <= mb_reg >> 1;
            end
            OP_ZERO:
            begin
                va_reg <= '0;
                vb_reg <= '0;
            end
            OP_MDT_A:   sgn_reg <= va_reg[VEC_W-1];
            OP_MDT_B:   sgn_reg <= vb_reg[VEC_W-1];
            OP_VEL_A:   va_reg <= VEC_W'(vel_x_reg) + step_s;
            OP_VEL_B:   vb_reg <= VEC_W'(vel_y_reg) + step_s;
            OP_COMMIT_VEL:
            begin
                va_reg <= VEC_W'(sat24(va_reg));
                vb_reg <= VEC_W'(sat24(vb_reg));
            end
            OP_POS_A:   va_reg <= VEC_W'(pos_x_reg) + step_s;
            OP_POS_B:   vb_reg <= VEC_W'(pos_y_reg) + step_s;
            OP_COMMIT_POS:
            begin
                opx_reg <= wrap_axis(va_reg, bound_x_reg, width_reg);
                opy_reg <= wrap_axis(vb_reg, bound_y_reg, height_reg);
                ovx_reg <= vel_x_reg;
                ovy_reg <= vel_y_reg;
            end
            default: ;
        endcase
    end

    assign position_x = opx_reg;
    assign position_y = opy_reg;
    assign velocity_x = ovx_reg;
    assign velocity_y = ovy_reg;
endmodule

// ===== rtl/sks_ctrl.sv =====
// Controller: sequences the datapath through one steering step.
module sks_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  logic                 out_ready,
    input  sks_pkg::sks_status_t status,
    output sks_pkg::sks_cmd_t    cmd
);
    import sks_pkg::*;

    sks_state_t state_reg, state_next;
    logic       spd_reg, spd_next;       // 0: accel clamp, 1: speed clamp
    logic       shifted_reg, shifted_next;
    logic       out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            spd_reg       <= 1'b0;
            shifted_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            spd_reg       <= spd_next;
            shifted_reg   <= shifted_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        spd_next       = spd_reg;
        shifted_next   = shifted_reg;
        out_valid_next = out_valid_reg && !out_ready;
        in_ready       = 1'b0;
        cmd.op         = OP_NONE;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op     = OP_LOAD;
                    spd_next   = 1'b0;
                    state_next = S_ADIV_A;
                end
            end
            S_ADIV_A:
            begin
                cmd.op     = OP_ADIV_A;
                state_next = S_ADIV_A_W;
            end
            S_ADIV_A_W:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = OP_SET_A;
                    state_next = S_ADIV_B;
                end
            end
            S_ADIV_B:
            begin
                cmd.op     = OP_ADIV_B;
                state_next = S_ADIV_B_W;
            end
            S_ADIV_B_W:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = OP_SET_B;
                    state_next = S_LIM_INIT;
                end
            end
            S_LIM_INIT:
            begin
                cmd.op       = spd_reg ? OP_LIM_SPD : OP_LIM_ACC;
                shifted_next = 1'b0;
                state_next   = S_LIM_CHK;
            end
            S_LIM_CHK:  state_next = status.over ? S_SHIFT : S_SQ_A;
            S_SQ_A:
            begin
                cmd.op     = OP_SQ_A;
                state_next = S_SQ_B;
            end
            S_SQ_B:
            begin
                cmd.op     = OP_SQ_B;
                state_next = S_SQ_SUM;
            end
            S_SQ_SUM:
            begin
                cmd.op     = OP_SQ_SUM;
                state_next = shifted_reg ? S_SQRT : S_LIM_SQ;
            end
            S_LIM_SQ:
            begin
                cmd.op     = OP_LIM_SQ;
                state_next = S_LIM_CMP;
            end
            S_LIM_CMP:  state_next = status.fits ? S_LIM_END : S_SHIFT;
            S_SHIFT:
            begin
                if (status.wide)
                begin
                    cmd.op = OP_SHIFT;
                end
                else
                begin
                    shifted_next = 1'b1;
                    state_next   = S_SQ_A;
                end
            end
            S_SQRT:
            begin
                cmd.op     = OP_SQRT;
                state_next = S_SQRT_W;
            end
            S_SQRT_W:
            begin
                if (!status.sqrt_busy)
                begin
                    if (status.m_zero)
                    begin
                        cmd.op     = OP_ZERO;
                        state_next = S_LIM_END;
                    end
                    else
                    begin
                        state_next = S_SC_A;
                    end
                end
            end
            S_SC_A:
            begin
                cmd.op     = OP_SCALE_A;
                state_next = S_SD_A;
            end
            S_SD_A:
            begin
                cmd.op     = OP_SDIV_A;
                state_next = S_SD_A_W;
            end
            S_SD_A_W:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = OP_SET_A;
                    state_next = S_SC_B;
                end
            end
            S_SC_B:
            begin
                cmd.op     = OP_SCALE_B;
                state_next = S_SD_B;
            end
            S_SD_B:
            begin
                cmd.op     = OP_SDIV_B;
                state_next = S_SD_B_W;
            end
            S_SD_B_W:
            begin
                if (!status.div_busy)
                begin
                    cmd.op     = OP_SET_B;
                    state_next = S_LIM_END;
                end
            end
            S_LIM_END:  state_next = spd_reg ? S_VCOMMIT : S_MV_A;
            S_MV_A:
            begin
                cmd.op     = OP_MDT_A;
                state_next = S_AV_A;
            end
            S_AV_A:
            begin
                cmd.op     = OP_VEL_A;
                state_next = S_MV_B;
            end
            S_MV_B:
            begin
                cmd.op     = OP_MDT_B;
                state_next = S_AV_B;
            end
            S_AV_B:
            begin
                cmd.op     = OP_VEL_B;
                spd_next   = 1'b1;
                state_next = S_LIM_INIT;
            end
            S_VCOMMIT:
            begin
                cmd.op     = OP_COMMIT_VEL;
                state_next = S_MP_A;
            end
            S_MP_A:
            begin
                cmd.op     = OP_MDT_A;
                state_next = S_AP_A;
            end
            S_AP_A:
            begin
                cmd.op     = OP_POS_A;
                state_next = S_MP_B;
            end
            S_MP_B:
            begin
                cmd.op     = OP_MDT_B;
                state_next = S_AP_B;
            end
            S_AP_B:
            begin
                cmd.op     = OP_POS_B;
                state_next = S_COMMIT;
            end
            S_COMMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.op         = OP_COMMIT_POS;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:    state_next = S_IDLE;
        endcase
    end

    assign out_valid = out_valid_reg;
endmodule

// ===== tb/tb_top.sv =====
// Testbench for the seek steering step: directed table, random phases, scoreboard.
`timescale 1ns / 1ps

module tb_top;
    import sks_pkg::*;

    localparam int HALF = 5;                  // 10 ns clock
    localparam int SAMPLE_DLY = HALF - 1;     // just ahead of the rising edge
    localparam int SETTLE_CYCLES = 500;
    localparam int LONG_HOLD = 3000;          // long receiver hold-off
    localparam longint CYCLE_LIMIT = 4000000;
    localparam int RANDOM_ITEMS = 840;
    localparam int RANDOM_PHASES = 9;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = CFG_IDX_W'(7);

    typedef logic signed [FIELD_W-1:0] fld_t;

    typedef struct {
        fld_t pos_x;
        fld_t pos_y;
        fld_t vel_x;
        fld_t vel_y;
    } motion_t;

    typedef struct {
        fld_t            goal_x;
        fld_t            goal_y;
        logic [DT_W-1:0] dt;
        bit              typed;   // expected value given in the row
        motion_t         want;
    } goal_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    sks_in_if  tgt ();
    sks_out_if upd ();
    sks_cfg_if cfg ();

    seek_steering_kinematic_step uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .target (tgt),
        .update (upd),
        .cfg    (cfg)
    );

    always
    begin
        #HALF clk = 1'b1;
        #HALF clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow copy of the block: registers and agent state
    // ------------------------------------------------------------------
    longint unsigned sh_bound_x, sh_bound_y, sh_arrive, sh_accel, sh_speed;
    longint unsigned sh_width, sh_height;
    longint          sh_px, sh_py, sh_vx, sh_vy;

    motion_t motion_q[$];     // expected updates, oldest first
    int      n_errors = 0;
    longint  n_cycles = 0;
    int      send_idle_pct = 0;
    int      recv_idle_pct = 0;
    int      recv_hold = 0;   // cycles the receiver keeps ready low

    function automatic longint sat_field(longint v);
        if (v > 64'sd8388607)
            return 64'sd8388607;
        if (v < -64'sd8388608)
            return -64'sd8388608;
        return v;
    endfunction

    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n)
            b >>= 2;
        while (b != 0)
        begin
            if (n >= res + b)
            begin
                n -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return res;
    endfunction

    // Magnitude clamp of (a, b) to lim; same fixed-point scale throughout.
    function automatic void clamp_mag(inout longint a, inout longint b,
                                      input longint unsigned lim);
        longint unsigned ma, mb, m;
        ma = (a < 0) ? longint'(-a) : longint'(a);
        mb = (b < 0) ? longint'(-b) : longint'(b);
        // both components small and the squared sum within reach: untouched
        if (ma <= lim && mb <= lim && ma * ma + mb * mb <= lim * lim)
            return;
        while (ma >= (64'd1 << 30) || mb >= (64'd1 << 30))
        begin
            ma >>= 1;
            mb >>= 1;
        end
        m = floor_root(ma * ma + mb * mb);
        if (m == 0)
        begin
            a = 0;
            b = 0;
            return;
        end
        ma = ma * lim / m;
        mb = mb * lim / m;
        a = (a < 0) ? -longint'(ma) : longint'(ma);
        b = (b < 0) ? -longint'(mb) : longint'(mb);
    endfunction

    function automatic longint wrap_pos(longint p, longint unsigned bound,
                                        longint unsigned size);
        longint hi, lo;
        hi = longint'(bound << FRAC_BITS);
        lo = -longint'(size << FRAC_BITS);
        if (p > hi)
            p = lo;
        else if (p < lo)
            p = hi;
        return sat_field(p);
    endfunction

    // Advance the shadow agent by one goal beat and return the new motion.
    function automatic motion_t steer_step(fld_t gx, fld_t gy, logic [DT_W-1:0] dt_in);
        longint  dt, at, cx, cy, ax, ay, vx, vy, px, py;
        motion_t r;
        dt = longint'(dt_in);
        at = (sh_arrive == 0) ? 1 : longint'(sh_arrive);   // zero arrive time acts as one
        cx = sh_px + longint'((sh_width << FRAC_BITS) / 2);
        cy = sh_py + longint'((sh_height << FRAC_BITS) / 2);
        ax = (longint'(gx) - cx) * 256 / at;
        ay = (longint'(gy) - cy) * 256 / at;
        clamp_mag(ax, ay, sh_accel << FRAC_BITS);
        vx = sh_vx + ax * dt / 65536;
        vy = sh_vy + ay * dt / 65536;
        clamp_mag(vx, vy, sh_speed << FRAC_BITS);
        sh_vx = sat_field(vx);
        sh_vy = sat_field(vy);
        px = sh_px + sh_vx * dt / 65536;
        py = sh_py + sh_vy * dt / 65536;
        sh_px = wrap_pos(px, sh_bound_x, sh_width);
        sh_py = wrap_pos(py, sh_bound_y, sh_height);
        r.pos_x = fld_t'(sh_px);
        r.pos_y = fld_t'(sh_py);
        r.vel_x = fld_t'(sh_vx);
        r.vel_y = fld_t'(sh_vy);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Channel drivers: change at the falling edge, look just before rise
    // ------------------------------------------------------------------
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg.valid = 1'b1;
        cfg.index = idx;
        cfg.data  = val;
        #SAMPLE_DLY;
        while (!cfg.ready)
        begin
            @(negedge clk);
            #SAMPLE_DLY;
        end
        case (idx)
            REG_BOUND_X:       sh_bound_x = val & 16'hFFF;
            REG_BOUND_Y:       sh_bound_y = val & 16'hFFF;
            REG_ARRIVE_TIME:   sh_arrive  = val;
            REG_ACCEL_LIMIT:   sh_accel   = val;
            REG_SPEED_LIMIT:   sh_speed   = val;
            REG_SPRITE_WIDTH:  sh_width   = val & 16'h3FF;
            REG_SPRITE_HEIGHT: sh_height  = val & 16'h3FF;
            default: ;         // unknown index: dropped
        endcase
        @(negedge clk);
        cfg.valid = 1'b0;
    endtask

    task automatic write_all(int bx, int by, int at, int al, int sl, int sw, int shh);
        write_reg(REG_BOUND_X, CFG_DATA_W'(bx));
        write_reg(REG_BOUND_Y, CFG_DATA_W'(by));
        write_reg(REG_ARRIVE_TIME, CFG_DATA_W'(at));
        write_reg(REG_ACCEL_LIMIT, CFG_DATA_W'(al));
        write_reg(REG_SPEED_LIMIT, CFG_DATA_W'(sl));
        write_reg(REG_SPRITE_WIDTH, CFG_DATA_W'(sw));
        write_reg(REG_SPRITE_HEIGHT, CFG_DATA_W'(shh));
    endtask

    // Offer one goal beat; valid stays high into the next call if no gap is drawn.
    task automatic send_goal(goal_row_t row);
        motion_t m;
        while ($urandom_range(99) < send_idle_pct)
        begin
            tgt.valid = 1'b0;
            @(negedge clk);
        end
        tgt.valid     = 1'b1;
        tgt.goal_x    = row.goal_x;
        tgt.goal_y    = row.goal_y;
        tgt.time_step = row.dt;
        #SAMPLE_DLY;
        while (!tgt.ready)
        begin
            @(negedge clk);
            #SAMPLE_DLY;
        end
        m = steer_step(row.goal_x, row.goal_y, row.dt);
        motion_q.push_back(row.typed ? row.want : m);
        @(negedge clk);
    endtask

    // Block idle: every update in, then the settle window.
    task automatic drain;
        tgt.valid = 1'b0;
        while (motion_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver and scoreboard
    // ------------------------------------------------------------------
    initial
    begin
        motion_t want;
        upd.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (recv_hold > 0)
            begin
                upd.ready = 1'b0;
                recv_hold = recv_hold - 1;
            end
            else
                upd.ready = ($urandom_range(99) >= recv_idle_pct);
            #SAMPLE_DLY;
            if (upd.valid && upd.ready)
            begin
                if (motion_q.size() == 0)
                begin
                    n_errors++;
                    $display("%0t: update beat with nothing expected: pos %0d,%0d vel %0d,%0d",
                             $time, upd.position_x, upd.position_y,
                             upd.velocity_x, upd.velocity_y);
                end
                else
                begin
                    want = motion_q.pop_front();
                    if (upd.position_x !== want.pos_x)
                    begin
                        n_errors++;
                        $display("%0t: position_x expected %0d actual %0d",
                                 $time, want.pos_x, upd.position_x);
                    end
                    if (upd.position_y !== want.pos_y)
                    begin
                        n_errors++;
                        $display("%0t: position_y expected %0d actual %0d",
                                 $time, want.pos_y, upd.position_y);
                    end
                    if (upd.velocity_x !== want.vel_x)
                    begin
                        n_errors++;
                        $display("%0t: velocity_x expected %0d actual %0d",
                                 $time, want.vel_x, upd.velocity_x);
                    end
                    if (upd.velocity_y !== want.vel_y)
                    begin
                        n_errors++;
                        $display("%0t: velocity_y expected %0d actual %0d",
                                 $time, want.vel_y, upd.velocity_y);
                    end
                end
            end
        end
    end

    // Hang guard.
    always @(posedge clk)
    begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Random content
    // ------------------------------------------------------------------
    function automatic fld_t rand_goal(longint unsigned bound, longint unsigned size);
        int sel;
        int px;
        sel = $urandom_range(7);
        if (sel == 0)
            return fld_t'($urandom);                          // anything in the field
        if (sel == 1)
            return $urandom_range(1) ? fld_t'(24'h7FFFFF) : fld_t'(24'h800000);
        // mostly somewhere on or just off the screen
        px = $urandom_range(int'(bound + size) + 64) - 32 - int'(size);
        return fld_t'((px <<< FRAC_BITS) + $urandom_range(255));
    endfunction

    function automatic logic [DT_W-1:0] rand_dt();
        case ($urandom_range(5))
            0:       return DT_W'($urandom);
            1:       return $urandom_range(1) ? DT_W'(16'hFFFF) : DT_W'(0);
            default: return DT_W'($urandom_range(3000, 300));   // frame-ish times
        endcase
    endfunction

    function automatic int rand_lim();
        case ($urandom_range(7))
            0:       return 0;
            1:       return 65535;
            2:       return $urandom_range(65535);
            default: return $urandom_range(400);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin
        goal_row_t rows[$];
        goal_row_t r;
        int        per_phase;

        tgt.valid = 1'b0;
        tgt.goal_x = '0;
        tgt.goal_y = '0;
        tgt.time_step = '0;
        cfg.valid = 1'b0;
        cfg.index = '0;
        cfg.data = '0;

        // register defaults and starting agent state after reset
        sh_bound_x = 1280;
        sh_bound_y = 800;
        sh_arrive  = 512;
        sh_accel   = 20;
        sh_speed   = 150;
        sh_width   = 64;
        sh_height  = 64;
        sh_px = 1220 * 256;
        sh_py = 700 * 256;
        sh_vx = 0;
        sh_vy = 0;

        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed part. Goal right on the centre after reset: agent stays put.
        r = '{goal_x: fld_t'(1252 * 256), goal_y: fld_t'(732 * 256), dt: 16'd1000,
              typed: 1'b1, want: '{fld_t'(1220 * 256), fld_t'(700 * 256), '0, '0}};
        rows.push_back(r);
        r.typed = 1'b0;
        r.goal_x = 24'h7FFFFF; r.goal_y = 24'h7FFFFF; r.dt = 16'hFFFF; rows.push_back(r);
        r.goal_x = 24'h800000; r.goal_y = 24'h800000; r.dt = 16'hFFFF; rows.push_back(r);
        r.goal_x = 24'h7FFFFF; r.goal_y = 24'h800000; r.dt = 16'h0000; rows.push_back(r);
        r.goal_x = 24'h800000; r.goal_y = 24'h7FFFFF; r.dt = 16'h8000; rows.push_back(r);
        r.goal_x = 24'h000000; r.goal_y = 24'h000000; r.dt = 16'h0444; rows.push_back(r);
        foreach (rows[i])
            send_goal(rows[i]);
        drain();

        // Widest settings: zero arrive time acts as one, bounds zero so wraps fire.
        write_all(0, 0, 0, 65535, 65535, 1023, 1023);
        write_reg(REG_UNUSED, 16'hFFFF);              // unknown index is ignored
        rows.delete();
        r.goal_x = 24'h7FFFFF; r.goal_y = 24'h800000; r.dt = 16'hFFFF; rows.push_back(r);
        r.goal_x = 24'h800000; r.goal_y = 24'h7FFFFF; r.dt = 16'hFFFF; rows.push_back(r);
        r.goal_x = 24'h012345; r.goal_y = 24'hFEDCBA; r.dt = 16'h7FFF; rows.push_back(r);
        r.goal_x = 24'h000000; r.goal_y = 24'h000000; r.dt = 16'h0001; rows.push_back(r);
        foreach (rows[i])
            send_goal(rows[i]);
        drain();

        // Zero limits: any nonzero vector collapses to zero.
        write_all(4095, 4095, 65535, 0, 0, 0, 0);
        rows.delete();
        r.goal_x = 24'h100000; r.goal_y = 24'h0F0000; r.dt = 16'hFFFF; rows.push_back(r);
        r.goal_x = 24'h800000; r.goal_y = 24'h800000; r.dt = 16'h1234; rows.push_back(r);
        foreach (rows[i])
            send_goal(rows[i]);
        drain();

        // Speed clamp tight, acceleration loose.
        write_all(640, 480, 1, 65535, 3, 32, 16);
        rows.delete();
        r.goal_x = 24'h7FFFFF; r.goal_y = 24'h000100; r.dt = 16'hFFFF; rows.push_back(r);
        r.goal_x = 24'h800000; r.goal_y = 24'h800000; r.dt = 16'hC000; rows.push_back(r);
        r.goal_x = 24'h000000; r.goal_y = 24'h7FFFFF; r.dt = 16'h0400; rows.push_back(r);
        foreach (rows[i])
            send_goal(rows[i]);
        drain();

        // Random phases: receiver-heavy idling, sender-heavy idling, then none.
        per_phase = RANDOM_ITEMS / RANDOM_PHASES;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            if (ph < 3)
            begin
                send_idle_pct = 19;
                recv_idle_pct = 85;
            end
            else if (ph < 6)
            begin
                send_idle_pct = 85;
                recv_idle_pct = 19;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            write_all($urandom_range(4095), $urandom_range(4095),
                      ($urandom_range(4) == 0) ? $urandom_range(65535)
                                               : $urandom_range(2048, 32),
                      rand_lim(), rand_lim(),
                      $urandom_range(1023), $urandom_range(1023));
            if (ph == 7)
                recv_hold = LONG_HOLD;   // block fills and stalls target
            for (int k = 0; k < per_phase; k++)
            begin
                r.typed  = 1'b0;
                r.goal_x = rand_goal(sh_bound_x, sh_width);
                r.goal_y = rand_goal(sh_bound_y, sh_height);
                r.dt     = rand_dt();
                send_goal(r);
            end
            drain();   // sender pauses until every update is back
        end

        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
